// File: hdl/stepper_step_pulse_generator_core_macros.svh
// Assertion macros shared by the stepper step pulse generator RTL.
`ifndef STEPPER_STEP_PULSE_GENERATOR_CORE_MACROS_SVH
`define STEPPER_STEP_PULSE_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define SSPG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sspg assertion failed");
// Check that a condition implies a property in the next cycle.
`define SSPG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sspg assertion failed");
`else
`define SSPG_ASSERT(name, clk, rst, prop)
`define SSPG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: hdl/sspg_pkg.sv
// Types and constants of the stepper step pulse generator.
package sspg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_SET  = 2'd2
  } req_t;

  localparam int unsigned REQ_BITS      = 2;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_BITS      = 16;
  localparam int unsigned INTERVAL_BITS = 24;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned TARGET_BITS   = 32;

  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [INTERVAL_BITS-1:0] interval_t;

  localparam cfg_idx_t CFG_START_INTERVAL = 1'd0;
  localparam cfg_idx_t CFG_MIN_INTERVAL   = 1'd1;

  localparam logic [CFG_BITS-1:0] START_RESET = 16'd1400;
  localparam logic [CFG_BITS-1:0] MIN_RESET   = 16'd1000;

  localparam interval_t INTERVAL_MAX = 24'hFF_FFFF;
  localparam interval_t GROW_STEP    = 24'd10;
  localparam interval_t SHRINK_STEP  = 24'd20;

  localparam int unsigned NEAR_COUNT = 20;
  localparam int unsigned OVERSHOOT  = 20;

endpackage

// File: hdl/stepper_step_pulse_generator_core.sv
// Stepper step pulse generator: ticks, moves and position sets, one item per cycle unless out_ready stalls.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls; the motion state updates as an
//   item moves from the input register to the result register, so the next item sees it at once.
// Reset (rst, synchronous): position and targets 0, interval 1400, direction down,
//   configuration back to 1400 / 1000, both pipeline registers empty.
`include "stepper_step_pulse_generator_core_macros.svh"

module stepper_step_pulse_generator_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  sspg_pkg::cfg_idx_t                   cfg_index,
  input  logic [sspg_pkg::CFG_BITS-1:0]        cfg_wdata,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sspg_pkg::REQ_BITS-1:0]        req_type,
  input  logic signed [sspg_pkg::TARGET_BITS-1:0] target_position,
  input  logic [sspg_pkg::TIME_BITS-1:0]       now_us,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 step_pulse,
  output logic                                 direction_down,
  output logic signed [sspg_pkg::TARGET_BITS-1:0] position_now,
  output logic                                 running
);

  import sspg_pkg::*;

  localparam int unsigned P = POSITION_BITS;
  localparam logic [P-1:0] POS_ONE       = P'(1);
  localparam logic [P-1:0] POS_NEAR      = P'(NEAR_COUNT);
  localparam logic [P-1:0] POS_OVERSHOOT = P'(OVERSHOOT);

  // configuration registers
  logic [CFG_BITS-1:0] launch_interval;
  logic [CFG_BITS-1:0] min_interval;

  // input register
  logic                   in_held;
  logic [REQ_BITS-1:0]    in_req;
  logic [TARGET_BITS-1:0] in_target;
  logic [TIME_BITS-1:0]   in_now;

  // motion state
  logic [P-1:0]         cur_pos, imm_target, fin_target;
  interval_t            step_interval;
  logic [TIME_BITS-1:0] last_step;
  logic                 dir_level;

  logic [P-1:0]         cur_pos_next, imm_target_next, fin_target_next;
  interval_t            step_interval_next;
  logic [TIME_BITS-1:0] last_step_next;
  logic                 dir_level_next;
  logic                 pulse_next;

  logic advance;

  // The held item moves on when the result register is empty or being drained.
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  // ---------------------------------------------------------------------------
  // Single-pass update of the motion state for the held item.
  // ---------------------------------------------------------------------------
  logic [63:0]          tgt_wide;
  logic [P-1:0]         tgt_p;
  logic                 at_imm, done;
  logic [P-1:0]         tick_tgt;
  interval_t            tick_si, stepped_si;
  logic                 tick_dir, go_up, go, near;
  logic [TIME_BITS-1:0] elapsed;
  logic [P-1:0]         leg_dist;
  logic                 move_down_rev, move_up_rev;

  always_comb begin
    // 32-bit target sign-extended, then wrapped to the position width
    tgt_wide = 64'($signed(in_target));
    tgt_p    = tgt_wide[P-1:0];

    // tick: adopt the final target once the immediate one is reached
    at_imm   = (cur_pos == imm_target);
    done     = at_imm && (cur_pos == fin_target);
    tick_tgt = at_imm ? fin_target : imm_target;
    tick_si  = at_imm ? INTERVAL_BITS'(launch_interval) : step_interval;
    tick_dir = at_imm ? ($signed(fin_target) < $signed(cur_pos)) : dir_level;

    elapsed = in_now - last_step;
    go      = !done && (elapsed >= TIME_BITS'(tick_si));
    go_up   = $signed(cur_pos) < $signed(tick_tgt);
    // distance before the step; after it the distance is one less
    leg_dist = go_up ? (tick_tgt - cur_pos) : (cur_pos - tick_tgt);
    near     = (leg_dist <= POS_NEAR);

    // ramp: slow down near the target, speed up elsewhere while above the minimum interval
    if (near) begin
      stepped_si = (tick_si > (INTERVAL_MAX - GROW_STEP)) ? INTERVAL_MAX
                                                           : tick_si + GROW_STEP;
    end else if (tick_si > INTERVAL_BITS'(min_interval)) begin
      stepped_si = (tick_si < SHRINK_STEP) ? '0 : tick_si - SHRINK_STEP;
    end else begin
      stepped_si = tick_si;
    end

    // move: reversal while running
    move_down_rev = ($signed(tgt_p) < $signed(cur_pos)) &&
                    ($signed(cur_pos) < $signed(fin_target));
    move_up_rev   = ($signed(cur_pos) < $signed(tgt_p)) &&
                    ($signed(fin_target) < $signed(cur_pos));

    cur_pos_next       = cur_pos;
    imm_target_next    = imm_target;
    fin_target_next    = fin_target;
    step_interval_next = step_interval;
    last_step_next     = last_step;
    dir_level_next     = dir_level;
    pulse_next         = 1'b0;

    unique case (req_t'(in_req))
      REQ_TICK: begin
        if (!done) begin
          imm_target_next    = tick_tgt;
          step_interval_next = tick_si;
          dir_level_next     = tick_dir;
          if (go) begin
            cur_pos_next       = go_up ? (cur_pos + POS_ONE) : (cur_pos - POS_ONE);
            last_step_next     = in_now;
            step_interval_next = stepped_si;
            pulse_next         = 1'b1;
          end
        end
      end
      REQ_MOVE: begin
        fin_target_next = tgt_p;
        if (move_down_rev) begin
          imm_target_next = cur_pos - POS_OVERSHOOT;
        end else if (move_up_rev) begin
          imm_target_next = cur_pos + POS_OVERSHOOT;
        end else begin
          imm_target_next = tgt_p;
          if (at_imm) begin
            step_interval_next = INTERVAL_BITS'(launch_interval);
            dir_level_next     = $signed(tgt_p) < $signed(cur_pos);
          end
        end
      end
      REQ_SET: begin
        cur_pos_next    = tgt_p;
        imm_target_next = tgt_p;
        fin_target_next = tgt_p;
      end
      default: begin
        // unused request code: hold everything
      end
    endcase
  end

  logic [63:0] pos_wide;
  assign pos_wide = 64'($signed(cur_pos_next));

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      launch_interval <= START_RESET;
      min_interval    <= MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_INTERVAL: launch_interval <= cfg_wdata;
        CFG_MIN_INTERVAL:   min_interval    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register: load on accept, drop when the item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req    <= req_type;
      in_target <= target_position;
      in_now    <= now_us;
    end
  end

  // motion state advances together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos       <= '0;
      imm_target    <= '0;
      fin_target    <= '0;
      step_interval <= INTERVAL_BITS'(START_RESET);
      last_step     <= '0;
      dir_level     <= 1'b1;
    end else if (advance) begin
      cur_pos       <= cur_pos_next;
      imm_target    <= imm_target_next;
      fin_target    <= fin_target_next;
      step_interval <= step_interval_next;
      last_step     <= last_step_next;
      dir_level     <= dir_level_next;
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step_pulse     <= pulse_next;
      direction_down <= dir_level_next;
      position_now   <= $signed(pos_wide[TARGET_BITS-1:0]);
      running        <= (cur_pos_next != imm_target_next);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SSPG_ASSERT_NEXT(a_pulse_only_on_tick, clk, rst, advance && (in_req != REQ_TICK), !step_pulse)
  `SSPG_ASSERT_NEXT(a_step_moves, clk, rst, advance && pulse_next, cur_pos != $past(cur_pos))
  `SSPG_ASSERT_NEXT(a_hold_idle, clk, rst, !advance, $stable(cur_pos) && $stable(imm_target))

endmodule

// File: tb/stepper_step_pulse_generator_core_test.sv
// Self-checking testbench for the stepper step pulse generator core.
module stepper_step_pulse_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sspg_pkg::*;

  // Request code 3 has no enum member in the package; the block must ignore it.
  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
  // Input register plus result register, from the header of the core.
  localparam int unsigned LATENCY_CYCLES = 2;

  typedef struct packed {
    logic                          pulse;
    logic                          dir_down;
    logic signed [TARGET_BITS-1:0] position;
    logic                          running;
  } motion_report_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  cfg_idx_t                      cfg_index = CFG_START_INTERVAL;
  logic [CFG_BITS-1:0]           cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [REQ_BITS-1:0]           req_type = REQ_TICK;
  logic signed [TARGET_BITS-1:0] target_position = '0;
  logic [TIME_BITS-1:0]          now_us = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          step_pulse;
  logic                          direction_down;
  logic signed [TARGET_BITS-1:0] position_now;
  logic                          running;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stepper_step_pulse_generator_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .target_position(target_position),
    .now_us         (now_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .step_pulse     (step_pulse),
    .direction_down (direction_down),
    .position_now   (position_now),
    .running        (running)
  );

  // ---------------------------------------------------------------------------
  // Motion predictor: our own copy of the configuration and the motion state
  // ---------------------------------------------------------------------------
  logic [CFG_BITS-1:0]           start_cfg;
  logic [CFG_BITS-1:0]           min_cfg;
  logic signed [TARGET_BITS-1:0] motor_pos;
  logic signed [TARGET_BITS-1:0] leg_target;   // where the motor heads right now
  logic signed [TARGET_BITS-1:0] goal_target;  // where it ends up after any overshoot
  interval_t                     step_gap;
  logic [TIME_BITS-1:0]          last_step_us;
  logic                          dir_down;

  motion_report_t pending_reports[$];
  int unsigned    error_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  // Microsecond clock of the stimulus, advanced by send_tick; starts close to the wrap.
  logic [TIME_BITS-1:0] sim_now = 32'hFFFF_8000;

  function automatic void reset_motion();
    start_cfg    = START_RESET;
    min_cfg      = MIN_RESET;
    motor_pos    = '0;
    leg_target   = '0;
    goal_target  = '0;
    step_gap     = START_RESET;
    last_step_us = '0;
    dir_down     = 1'b1;
  endfunction

  function automatic motion_report_t predict_request(logic [REQ_BITS-1:0] kind,
                                                     logic signed [TARGET_BITS-1:0] tgt,
                                                     logic [TIME_BITS-1:0] now);
    motion_report_t       rep;
    logic [TIME_BITS-1:0] elapsed;
    longint               steps_left;
    logic                 stepped;
    stepped = 1'b0;
    case (kind)
      REQ_TICK: begin
        // Leg done but goal not reached: adopt the goal and restart the ramp.
        if (motor_pos == leg_target && motor_pos != goal_target) begin
          leg_target = goal_target;
          dir_down   = goal_target < motor_pos;
          step_gap   = start_cfg;
        end
        elapsed = now - last_step_us;
        if (motor_pos != leg_target && elapsed >= step_gap) begin
          stepped      = 1'b1;
          motor_pos    = (motor_pos < leg_target) ? motor_pos + 1 : motor_pos - 1;
          last_step_us = now;
          steps_left = longint'(leg_target) - longint'(motor_pos);
          if (steps_left < 0) steps_left = -steps_left;
          if (steps_left < longint'(NEAR_COUNT)) begin
            // Slow down near the end of the leg, saturating.
            step_gap = (step_gap > INTERVAL_MAX - GROW_STEP) ? INTERVAL_MAX
                                                              : step_gap + GROW_STEP;
          end else if (step_gap > min_cfg) begin
            step_gap = (step_gap < SHRINK_STEP) ? '0 : step_gap - SHRINK_STEP;
          end
        end
      end
      REQ_MOVE: begin
        if (tgt < motor_pos && motor_pos < goal_target) begin
          // Reversal while heading up: overshoot downward first.
          leg_target  = motor_pos - TARGET_BITS'(OVERSHOOT);
          goal_target = tgt;
        end else if (motor_pos < tgt && goal_target < motor_pos) begin
          leg_target  = motor_pos + TARGET_BITS'(OVERSHOOT);
          goal_target = tgt;
        end else begin
          if (motor_pos == leg_target) begin
            step_gap = start_cfg;
            dir_down = tgt < motor_pos;
          end
          leg_target  = tgt;
          goal_target = tgt;
        end
      end
      REQ_SET: begin
        motor_pos   = tgt;
        leg_target  = tgt;
        goal_target = tgt;
      end
      default: ;
    endcase
    rep.pulse    = stepped;
    rep.dir_down = dir_down;
    rep.position = motor_pos;
    rep.running  = motor_pos != leg_target;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall on out_ready, compare every accepted item
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    motion_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected item, expected none actual position %0d",
                 $time, position_now);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("step_pulse", want.pulse, step_pulse);
        check_field("direction_down", want.dir_down, direction_down);
        check_field("position_now", $signed(want.position), $signed(position_now));
        check_field("running", want.running, running);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one item, idling at random first; predict it at the accepting edge.
  task automatic send_request(logic [REQ_BITS-1:0] kind,
                              logic signed [TARGET_BITS-1:0] tgt,
                              logic [TIME_BITS-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= kind;
    target_position <= tgt;
    now_us          <= now;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(predict_request(kind, tgt, now));
  endtask

  // Advance the stimulus clock by up to spread microseconds and tick.
  task automatic send_tick(int unsigned spread);
    sim_now += $urandom_range(spread);
    send_request(REQ_TICK, $urandom, sim_now);
  endtask

  // Drop valid and hold off until every result is back and the pipe is empty.
  task automatic settle_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES + 2) @(posedge clk);
  endtask

  // Only call while the block is idle.
  task automatic write_register(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START_INTERVAL) start_cfg = value;
    else min_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_and_unused();
    send_request(REQ_TICK, '0, '0);         // idle at reset: no step
    send_request(REQ_UNUSED, '1, '1);       // ignored, reports state
    send_request(REQ_SET, '1, '0);          // position -1
    send_request(REQ_TICK, 32'sh7FFF_FFFF, '1);
  endtask

  task automatic test_position_extremes();
    send_request(REQ_SET, 32'sh8000_0000, $urandom);
    send_request(REQ_MOVE, 32'sh8000_0019, $urandom);
    send_tick(4000);
    send_request(REQ_MOVE, 32'sh7FFF_FFFF, $urandom);
    send_tick(4000);
  endtask

  task automatic test_reversal_overshoot();
    // Heading down near the top, then reverse: overshoot wraps past the maximum.
    send_request(REQ_SET, 32'sd2147483640, $urandom);
    send_request(REQ_MOVE, 32'sd2147483600, $urandom);
    send_tick(3000);
    send_request(REQ_MOVE, 32'sd2147483645, $urandom);
    send_tick(3000);
    send_tick(3000);
    // Mirror case near the bottom: overshoot wraps past the minimum.
    send_request(REQ_SET, -32'sd2147483640, $urandom);
    send_request(REQ_MOVE, -32'sd2147483600, $urandom);
    send_tick(3000);
    send_request(REQ_MOVE, -32'sd2147483645, $urandom);
    send_tick(3000);
  endtask

  task automatic test_zero_interval();
    // Minimum below the shrink step: the interval collapses to zero after one
    // step far from the target, then every tick steps even with no time passed.
    settle_pipeline();
    write_register(CFG_START_INTERVAL, 16'd15);
    write_register(CFG_MIN_INTERVAL, 16'd1);
    send_request(REQ_SET, '0, $urandom);
    send_request(REQ_MOVE, 32'sd100, $urandom);
    sim_now += 40;
    send_tick(0);
    send_tick(0);
    send_tick(0);
  endtask

  task automatic test_random_motion(int unsigned items, logic [CFG_BITS-1:0] start_value,
                                    logic [CFG_BITS-1:0] min_value);
    int unsigned                   sent;
    int unsigned                   pick;
    int unsigned                   span;
    logic signed [TARGET_BITS-1:0] aim;
    settle_pipeline();
    write_register(CFG_START_INTERVAL, start_value);
    write_register(CFG_MIN_INTERVAL, min_value);
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // One move with a run of ticks paced around the current interval;
        // now and then reverse mid-run.
        span = ($urandom_range(9) == 0) ? 600 : 60;
        aim  = motor_pos + int'($urandom_range(2 * span)) - int'(span);
        send_request(REQ_MOVE, aim, $urandom);
        sent++;
        repeat ($urandom_range(40, 3)) begin
          if ($urandom_range(9) == 0) begin
            aim = (goal_target > motor_pos) ? motor_pos - int'($urandom_range(60, 1))
                                            : motor_pos + int'($urandom_range(60, 1));
            send_request(REQ_MOVE, aim, $urandom);
          end else begin
            send_tick(int'(step_gap) * 3 / 2 + 2);
          end
          sent++;
        end
      end else if (pick < 75) begin
        case ($urandom_range(3))
          0:       aim = $urandom;
          1:       aim = 32'sh7FFF_FFFF - int'($urandom_range(30));
          2:       aim = 32'sh8000_0000 + int'($urandom_range(30));
          default: aim = int'($urandom_range(200)) - 100;
        endcase
        send_request(REQ_SET, aim, $urandom);
        sent++;
      end else if (pick < 90) begin
        // Noise: a tick at an arbitrary time or a move anywhere.
        if ($urandom_range(1) == 0) send_request(REQ_TICK, $urandom, $urandom);
        else send_request(REQ_MOVE, $urandom, $urandom);
        sent++;
      end else begin
        send_request(REQ_UNUSED, $urandom, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_motion();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_reset_and_unused();
    test_position_extremes();
    test_reversal_overshoot();
    test_zero_interval();

    // Sender idles lightly, receiver stalls hard.
    send_idle_pct = 35;
    recv_idle_pct = 82;
    test_random_motion(175, 16'hFFFF, 16'hFFFF);
    test_random_motion(175, START_RESET, MIN_RESET);

    // Swap the pressure.
    send_idle_pct = 82;
    recv_idle_pct = 35;
    test_random_motion(175, 16'd1, 16'd1);
    test_random_motion(175, 16'd300, 16'd40);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_motion(175, 16'hFFFF, 16'd1);
    test_random_motion(175, 16'd25, 16'd5);

    settle_pipeline();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: stepper_step_pulse_generator_core.f
+incdir+hdl
hdl/sspg_pkg.sv
hdl/stepper_step_pulse_generator_core.sv
tb/stepper_step_pulse_generator_core_test.sv
